// File: rtl/core/tets_pkg.sv
`timescale 1ns / 1ps

package tets_pkg;

	// Number of finger slots and the width of a slot index.
	localparam int FINGER_SLOTS = 10;
	localparam int SLOT_W = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

	// Key records with an id up to this value name a key and produce a key report.
	localparam int KEY_COUNT = 4;

	// Reset value of the press strength register.
	localparam logic [7:0] PRESS_STRENGTH_RST = 8'd10;

	typedef enum logic [1:0] {
		SLOT_FREE     = 2'd0,
		SLOT_PRESSED  = 2'd1,
		SLOT_RELEASED = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		KIND_FINGER = 2'd0,
		KIND_KEY    = 2'd1,
		KIND_SYNC   = 2'd2
	} report_kind_t;

	typedef enum logic [1:0] {
		REC_NONE   = 2'd0,
		REC_SCREEN = 2'd1,
		REC_KEY    = 2'd2,
		REC_OTHER  = 2'd3
	} rec_type_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_SCAN = 2'd1,
		SEQ_KEY  = 2'd2,
		SEQ_SYNC = 2'd3
	} seq_state_t;

	// One stored finger slot.
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  width;
		logic [7:0]  strength;
		slot_state_t status;
	} slot_entry_t;

	// Write request into the slot bank: a full record or the status alone.
	typedef struct packed {
		logic              en;
		logic              full;
		logic [SLOT_W-1:0] idx;
		slot_entry_t       entry;
	} slot_wr_t;

	// One decoded input item.
	typedef struct packed {
		logic       release_all;
		logic [7:0] status_byte;
		logic [7:0] position_high;
		logic [7:0] x_low;
		logic [7:0] y_low;
		logic [7:0] contact_width;
		logic       frame_last;
	} event_item_t;

	// One result item.
	typedef struct packed {
		report_kind_t kind;
		logic [3:0]   slot_index;
		logic [11:0]  x_coord;
		logic [11:0]  y_coord;
		logic [7:0]   touch_major;
		logic [7:0]   width_major;
		logic         touch_button;
		logic [1:0]   key_code;
		logic         key_pressed;
		logic         last;
	} report_t;

endpackage

// File: rtl/core/touch_event_slot_tracker.sv
`timescale 1ns / 1ps

// Touch event slot tracker. Each input item is one touch record or a release-all command;
// the block keeps ten finger slots and emits finger, key and sync reports on the output
// stream, with tlast on the final report of each item. A screen record or a record of
// another type that does not end its frame, a record skipped inside an aborted frame and a
// record with a bad report id leave the block idle and ready for the next record. A screen
// record that ends its frame walks all slots through the single slot read port, one slot
// per cycle while no report waits on a stalled output, and then emits the sync. A
// release-all walks the slots without a sync. A key record emits a key report and then the
// sync, or the sync alone when its id names no key, whether or not it ends the frame. A
// record of another type that ends its frame emits the sync alone. The input is not ready
// while an item is being worked on. The press strength register may be written at any
// time the block is idle and is always ready.
module touch_event_slot_tracker
	import tets_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write: press_strength.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// status_byte[7:0], position_high[15:8], x_low[23:16], y_low[31:24],
	// contact_width[39:32]
	input  logic [39:0] s_tdata,
	// operation[0]
	input  logic        s_tuser,
	// frame_last
	input  logic        s_tlast,
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot_index[3:0], x_coord[15:4], y_coord[27:16], touch_major[35:28],
	// width_major[43:36], touch_button[44], key_code[46:45], key_pressed[47]
	output logic [47:0] m_tdata,
	// report_kind[1:0]
	output logic [1:0]  m_tuser,
	// last
	output logic        m_tlast
);

	logic [7:0]              press_strength_q;
	event_item_t             item;
	slot_wr_t                wr;
	logic [SLOT_W-1:0]       rd_addr;
	slot_entry_t             rd_entry;
	logic [FINGER_SLOTS-1:0] active;
	report_t                 rep;

	// Press strength register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_strength_q <= PRESS_STRENGTH_RST;
		end else if (cfg_valid) begin
			press_strength_q <= cfg_data;
		end
	end

	// Unpack the input item.
	always_comb begin
		item.release_all   = s_tuser;
		item.status_byte   = s_tdata[7:0];
		item.position_high = s_tdata[15:8];
		item.x_low         = s_tdata[23:16];
		item.y_low         = s_tdata[31:24];
		item.contact_width = s_tdata[39:32];
		item.frame_last    = s_tlast;
	end

	tets_slot_bank u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.active   (active)
	);

	tets_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_item        (item),
		.press_strength (press_strength_q),
		.wr             (wr),
		.rd_addr        (rd_addr),
		.rd_entry       (rd_entry),
		.active         (active),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_report     (rep)
	);

	// Pack the result item.
	assign m_tdata = {rep.key_pressed, rep.key_code, rep.touch_button, rep.width_major,
		rep.touch_major, rep.y_coord, rep.x_coord, rep.slot_index};
	assign m_tuser = rep.kind;
	assign m_tlast = rep.last;

endmodule

// File: rtl/core/tets_slot_bank.sv
`timescale 1ns / 1ps

module tets_slot_bank
	import tets_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  slot_wr_t                wr,
	input  logic [SLOT_W-1:0]       rd_addr,
	output slot_entry_t             rd_entry,
	output logic [FINGER_SLOTS-1:0] active
);

	slot_state_t status_q [FINGER_SLOTS];
	logic [11:0] x_q [FINGER_SLOTS];
	logic [11:0] y_q [FINGER_SLOTS];
	logic [7:0]  width_q [FINGER_SLOTS];
	logic [7:0]  strength_q [FINGER_SLOTS];

	// Slot states start free; the other fields are only read once written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FINGER_SLOTS; i++) begin
				status_q[i] <= SLOT_FREE;
			end
		end else if (wr.en) begin
			status_q[wr.idx] <= wr.entry.status;
		end
	end

	// Record payload of a slot.
	always_ff @(posedge clk) begin
		if (wr.en && wr.full) begin
			x_q[wr.idx]        <= wr.entry.x;
			y_q[wr.idx]        <= wr.entry.y;
			width_q[wr.idx]    <= wr.entry.width;
			strength_q[wr.idx] <= wr.entry.strength;
		end
	end

	// Single read port for the scanning sequencer.
	always_comb begin
		rd_entry.x        = x_q[rd_addr];
		rd_entry.y        = y_q[rd_addr];
		rd_entry.width    = width_q[rd_addr];
		rd_entry.strength = strength_q[rd_addr];
		rd_entry.status   = status_q[rd_addr];
	end

	// Per-slot occupancy flags, used to find the final report of a release.
	always_comb begin
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			active[i] = (status_q[i] != SLOT_FREE);
		end
	end

endmodule

// File: rtl/core/tets_seq.sv
`timescale 1ns / 1ps

module tets_seq
	import tets_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  event_item_t             in_item,
	input  logic [7:0]              press_strength,
	output slot_wr_t                wr,
	output logic [SLOT_W-1:0]       rd_addr,
	input  slot_entry_t             rd_entry,
	input  logic [FINGER_SLOTS-1:0] active,
	output logic                    out_valid,
	input  logic                    out_ready,
	output report_t                 out_report
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FINGER_SLOTS - 1);
	localparam logic [3:0] ID_MAX = 4'(FINGER_SLOTS);
	localparam logic [3:0] KEY_ID_MAX = 4'(KEY_COUNT);

	seq_state_t state_q, state_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic skip_q, skip_d;
	logic release_q, release_d;
	logic button_q, button_d;
	logic [1:0] key_code_q, key_code_d;
	logic key_pressed_q, key_pressed_d;
	logic out_valid_q;
	report_t out_q, rep;
	logic load;
	logic out_free;
	logic [FINGER_SLOTS-1:0] above;

	// Fields of the incoming record.
	logic       rec_press;
	rec_type_t  rec_type;
	logic [3:0] rec_id;
	logic [3:0] rec_id_m1;

	assign rec_press = in_item.status_byte[7];
	assign rec_type  = rec_type_t'(in_item.status_byte[6:5]);
	assign rec_id    = in_item.status_byte[3:0];
	assign rec_id_m1 = rec_id - 4'd1;

	assign out_free = !out_valid_q || out_ready;
	assign rd_addr  = idx_q;
	assign in_ready = (state_q == SEQ_IDLE);

	// Slots after the one under the scan pointer.
	always_comb begin
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			above[i] = (SLOT_W'(i) > idx_q);
		end
	end

	// Sequencer: decode an item, then walk the slots or emit the key and sync reports it calls for.
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		skip_d        = skip_q;
		release_d     = release_q;
		button_d      = button_q;
		key_code_d    = key_code_q;
		key_pressed_d = key_pressed_q;
		wr            = '0;
		load          = 1'b0;
		rep           = '0;
		case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					if (in_item.release_all) begin
						state_d   = SEQ_SCAN;
						idx_d     = '0;
						release_d = 1'b1;
						button_d  = 1'b0;
					end else if (skip_q) begin
						if (in_item.frame_last) begin
							skip_d = 1'b0;
						end
					end else if (rec_id == 4'd0 || rec_id > ID_MAX) begin
						skip_d = !in_item.frame_last;
					end else begin
						case (rec_type)
							REC_SCREEN: begin
								wr.en       = 1'b1;
								wr.full     = 1'b1;
								wr.idx      = rec_id_m1[SLOT_W-1:0];
								wr.entry.x  = {in_item.position_high[3:0], in_item.x_low};
								wr.entry.y  = {in_item.position_high[7:4], in_item.y_low};
								wr.entry.width = in_item.contact_width;
								if (rec_press) begin
									wr.entry.strength = press_strength;
									wr.entry.status   = (press_strength != 8'd0) ?
										SLOT_PRESSED : SLOT_RELEASED;
								end else begin
									wr.entry.strength = 8'd0;
									wr.entry.status   = SLOT_RELEASED;
								end
								if (in_item.frame_last) begin
									state_d   = SEQ_SCAN;
									idx_d     = '0;
									release_d = 1'b0;
									button_d  = rec_press;
								end
							end
							REC_KEY: begin
								key_code_d    = rec_id_m1[1:0];
								key_pressed_d = rec_press;
								state_d       = (rec_id <= KEY_ID_MAX) ? SEQ_KEY : SEQ_SYNC;
								skip_d        = !in_item.frame_last;
							end
							default: begin
								if (in_item.frame_last) begin
									state_d = SEQ_SYNC;
								end
							end
						endcase
					end
				end
			end
			SEQ_SCAN: begin
				if (rd_entry.status == SLOT_FREE || out_free) begin
					if (rd_entry.status != SLOT_FREE) begin
						load             = 1'b1;
						rep.kind         = KIND_FINGER;
						rep.slot_index   = 4'(idx_q);
						rep.x_coord      = rd_entry.x;
						rep.y_coord      = rd_entry.y;
						rep.touch_major  = release_q ? 8'd0 : rd_entry.strength;
						rep.width_major  = rd_entry.width;
						rep.touch_button = button_q;
						rep.last         = release_q && !(|(active & above));
						wr.en            = 1'b1;
						wr.full          = 1'b0;
						wr.idx           = idx_q;
						wr.entry.status  = (release_q || rd_entry.status == SLOT_RELEASED) ?
							SLOT_FREE : rd_entry.status;
					end
					if (idx_q == LAST_SLOT) begin
						state_d = release_q ? SEQ_IDLE : SEQ_SYNC;
					end else begin
						idx_d = idx_q + SLOT_W'(1);
					end
				end
			end
			SEQ_KEY: begin
				if (out_free) begin
					load            = 1'b1;
					rep.kind        = KIND_KEY;
					rep.key_code    = key_code_q;
					rep.key_pressed = key_pressed_q;
					state_d         = SEQ_SYNC;
				end
			end
			SEQ_SYNC: begin
				if (out_free) begin
					load     = 1'b1;
					rep.kind = KIND_SYNC;
					rep.last = 1'b1;
					state_d  = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			idx_q       <= '0;
			skip_q      <= 1'b0;
			release_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			skip_q    <= skip_d;
			release_q <= release_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item context and the output register.
	always_ff @(posedge clk) begin
		button_q      <= button_d;
		key_code_q    <= key_code_d;
		key_pressed_q <= key_pressed_d;
		if (load) begin
			out_q <= rep;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_report = out_q;

	// A release-all item always starts a slot walk in release mode.
	a_release_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.release_all) |=> (state_q == SEQ_SCAN && release_q))
		else $error("release-all did not start a release scan");

	// The scan pointer never leaves the slot range.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_SCAN) |-> (idx_q <= LAST_SLOT))
		else $error("scan index out of range");

	// Finger reports name an existing slot.
	a_finger_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_FINGER) |-> (out_q.slot_index < ID_MAX))
		else $error("finger report with bad slot index");

	// A sync always closes the results of its item.
	a_sync_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_SYNC) |-> out_q.last)
		else $error("sync result without last");

endmodule
